/* rtl/core/pgse_pkg.sv */
// Shared constants and types for the grayscale PNG stored-block encoder.
package pgse_pkg;

   localparam int MAX_DIM_DEF     = 16384;
   localparam int BLOCK_MAX_DEF   = 65535;
   localparam int DIM_W           = 15;
   localparam int RAW_W           = 29;
   localparam logic [16:0] ADLER_MOD = 17'd65521;
   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // Emission phases of the byte sequencer.
   localparam logic [3:0] PH_PIXEL = 4'd0;
   localparam logic [3:0] PH_SIG   = 4'd1;
   localparam logic [3:0] PH_IHDR  = 4'd2;
   localparam logic [3:0] PH_IDATH = 4'd3;
   localparam logic [3:0] PH_BLKH  = 4'd4;
   localparam logic [3:0] PH_FILT  = 4'd5;
   localparam logic [3:0] PH_PIX   = 4'd6;
   localparam logic [3:0] PH_TAIL  = 4'd7;

   typedef logic [7:0] byte_type;

   function automatic logic [31:0] crc_table(input logic [7:0] idx);
      logic [31:0] c;
      c = {24'd0, idx};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      return (c >> 8) ^ crc_table(c[7:0] ^ b);
   endfunction

   function automatic byte_type be_byte(input logic [31:0] v, input logic [1:0] i);
      return v[31 - 8*i -: 8];
   endfunction

endpackage

/* rtl/core/png_gray_stored_encoder_top.sv */
// Top level of the grayscale PNG encoder using zlib stored blocks.
//
// Pixels enter on the req_ channel in raster order, one 8-bit value per
// transaction. Bytes of the PNG file leave on the rsp_ channel, one byte
// per transaction, with rsp_run_end on the last byte caused by a pixel and
// rsp_image_end on the last byte of the file. Width and height are written
// on the csr_ port while idle and are latched at the first pixel of a frame.
// A byte sequencer emits one byte per cycle into an output register while
// the output is not stalled; pixels inside a block then stream at one per
// cycle. The first pixel of a frame also emits the signature, IHDR and
// IDAT head, a pixel opening a row the filter byte, one opening a stored
// block the five-byte block header, and the last pixel the trailer. The
// CRC is one table lookup per byte. req_stall is high while the sequencer
// is busy, except while a non-final pixel byte goes out, or while the
// output register is full and stalled. rsp_stall holds rsp_ bytes
// unchanged. Reset empties the output register, drops any frame in
// progress and restores 16 by 16.
module png_gray_stored_encoder_top #(
   parameter int MAX_DIM          = pgse_pkg::MAX_DIM_DEF,
   parameter int STORED_BLOCK_MAX = pgse_pkg::BLOCK_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [pgse_pkg::DIM_W-1:0] csr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_run_end,
   output logic                     rsp_image_end
);
   import pgse_pkg::*;

   localparam int MAXD_I = (MAX_DIM > 32767) ? 32767 : MAX_DIM;
   localparam logic [DIM_W-1:0] MAXD = DIM_W'(MAXD_I);
   localparam logic [15:0] BMAX = 16'(STORED_BLOCK_MAX);
   // Block count by reciprocal multiply, exact for numerators below 2**30.
   localparam int BLK_L = $clog2(STORED_BLOCK_MAX);
   localparam int DIV_S = 30 + BLK_L;
   localparam logic [31:0] DIV_M =
      32'(((64'd1 << DIV_S) + 64'(STORED_BLOCK_MAX) - 64'd1) / 64'(STORED_BLOCK_MAX));

   logic [DIM_W-1:0] width_ff, height_ff, width_in, height_in;
   logic [DIM_W-1:0] lw_ff, lh_ff, lw_in, lh_in;
   logic [DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [15:0] blk_ff, blk_in;
   logic [RAW_W-1:0] raw_ff, raw_in;
   logic [15:0] sa_ff, sa_in, sb_ff, sb_in;
   logic [31:0] crc_ff, crc_in, hcrc_ff, hcrc_in;
   logic [31:0] zlen_ff, zlen_in;
   logic [RAW_W-1:0] nblk_ff, nblk_in;
   logic started_ff, started_in;
   logic [3:0] ph_ff, ph_in;
   logic [4:0] idx_ff, idx_in;
   logic busy_ff, busy_in;
   logic [7:0] pix_ff, pix_in;
   logic ov_ff, ov_in, ore_ff, ore_in, oie_ff, oie_in;
   logic [7:0] ob_ff, ob_in;
   logic last_ff, last_in;
   logic [1:0] setup_ff, setup_in;
   logic fdone_ff, fdone_in;

   logic out_free, accept, emit, done_pix;
   byte_type b;
   logic bcrc, hcrc_on, bend, bimg;
   logic [RAW_W-1:0] rawp;
   logic [15:0] n16;
   logic [DIM_W-1:0] cw, ch;
   logic [16:0] a_s, b_s;
   logic [16:0] a_n, b_n;
   logic [31:0] crcsel;
   logic [29:0] ceil_num;
   logic [61:0] quot_prod;

   assign out_free  = !ov_ff || !rsp_stall;
   assign emit      = busy_ff && out_free;
   // A plain pixel byte going out frees the input in the same cycle.
   assign done_pix  = emit && ph_ff == PH_PIX && !last_ff;
   assign req_stall = (busy_ff && !done_pix) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid     = ov_ff;
   assign rsp_out_byte  = ob_ff;
   assign rsp_run_end   = ore_ff;
   assign rsp_image_end = oie_ff;

   assign cw = (width_ff < DIM_W'(2)) ? DIM_W'(2) : (width_ff > MAXD ? MAXD : width_ff);
   assign ch = (height_ff < DIM_W'(1)) ? DIM_W'(1) : (height_ff > MAXD ? MAXD : height_ff);
   assign n16 = (raw_ff > RAW_W'(BMAX)) ? BMAX : raw_ff[15:0];

   always_comb begin
      b = 8'd0; bcrc = 1'b0; hcrc_on = 1'b0; bend = 1'b0; bimg = 1'b0;
      case (ph_ff)
         PH_SIG: begin
            case (idx_ff[2:0])
               3'd0: b = 8'h89; 3'd1: b = 8'h50; 3'd2: b = 8'h4E; 3'd3: b = 8'h47;
               3'd4: b = 8'h0D; 3'd5: b = 8'h0A; 3'd6: b = 8'h1A; default: b = 8'h0A;
            endcase
         end
         PH_IHDR: begin
            hcrc_on = (idx_ff >= 5'd4) && (idx_ff < 5'd21);
            case (idx_ff)
               5'd3: b = 8'd13;
               5'd4: b = "I"; 5'd5: b = "H"; 5'd6: b = "D"; 5'd7: b = "R";
               5'd8, 5'd9, 5'd10, 5'd11:
                  b = be_byte({17'd0, lw_ff}, idx_ff[1:0]);
               5'd12, 5'd13, 5'd14, 5'd15:
                  b = be_byte({17'd0, lh_ff}, idx_ff[1:0]);
               5'd16: b = 8'd8;
               5'd21, 5'd22, 5'd23, 5'd24:
                  b = be_byte(~hcrc_ff, idx_ff[1:0] - 2'd1);
               default: b = 8'd0;
            endcase
         end
         PH_IDATH: begin
            bcrc = idx_ff >= 5'd4;
            case (idx_ff)
               5'd0, 5'd1, 5'd2, 5'd3: b = be_byte(zlen_ff, idx_ff[1:0]);
               5'd4: b = "I"; 5'd5: b = "D"; 5'd6: b = "A"; 5'd7: b = "T";
               5'd8: b = 8'h78;
               default: b = 8'h01;
            endcase
         end
         PH_BLKH: begin
            bcrc = 1'b1;
            case (idx_ff[2:0])
               3'd0: b = {7'd0, RAW_W'(n16) == raw_ff};
               3'd1: b = n16[7:0];
               3'd2: b = n16[15:8];
               3'd3: b = ~n16[7:0];
               default: b = ~n16[15:8];
            endcase
         end
         PH_FILT: begin bcrc = 1'b1; b = 8'd0; end
         PH_PIX: begin bcrc = 1'b1; b = pix_ff; bend = !last_ff; end
         PH_TAIL: begin
            bcrc = idx_ff < 5'd4;
            bend = idx_ff == 5'd19;
            bimg = bend;
            case (idx_ff)
               5'd0, 5'd1, 5'd2, 5'd3: b = be_byte({sb_ff, sa_ff}, idx_ff[1:0]);
               5'd4, 5'd5, 5'd6, 5'd7: b = be_byte(~crc_ff, idx_ff[1:0]);
               5'd12: b = "I"; 5'd13: b = "E"; 5'd14: b = "N"; 5'd15: b = "D";
               5'd16: b = 8'hAE; 5'd17: b = 8'h42; 5'd18: b = 8'h60;
               5'd19: b = 8'h82;
               default: b = 8'd0;
            endcase
         end
         default: b = 8'd0;
      endcase
   end

   assign crcsel = crc_step(crc_ff, b);
   assign a_s = {1'b0, sa_ff} + {9'd0, b};
   assign a_n = (a_s >= ADLER_MOD) ? a_s - ADLER_MOD : a_s;
   assign b_s = {1'b0, sb_ff} + a_n;
   assign b_n = (b_s >= ADLER_MOD) ? b_s - ADLER_MOD : b_s;
   assign rawp = RAW_W'(lh_ff) * RAW_W'({1'b0, lw_ff} + 16'd1);
   assign ceil_num = {1'b0, raw_ff} + 30'(STORED_BLOCK_MAX - 1);
   assign quot_prod = 62'(ceil_num) * 62'(DIV_M);

   always_comb begin
      width_in = width_ff; height_in = height_ff; lw_in = lw_ff; lh_in = lh_ff;
      col_in = col_ff; row_in = row_ff; blk_in = blk_ff; raw_in = raw_ff;
      sa_in = sa_ff; sb_in = sb_ff; crc_in = crc_ff; hcrc_in = hcrc_ff;
      zlen_in = zlen_ff; nblk_in = nblk_ff; started_in = started_ff;
      ph_in = ph_ff; idx_in = idx_ff; busy_in = busy_ff; pix_in = pix_ff;
      ov_in = ov_ff; ore_in = ore_ff; oie_in = oie_ff; ob_in = ob_ff;
      last_in = last_ff; setup_in = setup_ff; fdone_in = fdone_ff;

      if (csr_write) begin
         if (csr_index == CSR_WIDTH) width_in = csr_data;
         else height_in = csr_data;
      end
      if (ov_ff && !rsp_stall) ov_in = 1'b0;

      // Frame setup beside the signature: raw length, block count, zlib length.
      if (setup_ff == 2'd3) begin
         raw_in = rawp; setup_in = 2'd2;
      end else if (setup_ff == 2'd2) begin
         nblk_in = RAW_W'(quot_prod >> DIV_S); setup_in = 2'd1;
      end else if (setup_ff == 2'd1) begin
         zlen_in = 32'd6 + 32'd5 * 32'(nblk_ff) + 32'(raw_ff);
         setup_in = 2'd0;
      end

      if (emit) begin
         ov_in = 1'b1; ob_in = b;
         oie_in = bimg;
         ore_in = bend;
         if (hcrc_on) hcrc_in = crc_step(hcrc_ff, b);
         if (bcrc) crc_in = crcsel;
         idx_in = idx_ff + 5'd1;
         case (ph_ff)
            PH_SIG: if (idx_ff == 5'd7) begin ph_in = PH_IHDR; idx_in = 5'd0; end
            PH_IHDR: if (idx_ff == 5'd24) begin ph_in = PH_IDATH; idx_in = 5'd0; end
            PH_IDATH: if (idx_ff == 5'd9) begin
               ph_in = PH_BLKH; idx_in = 5'd0;
            end
            PH_BLKH: if (idx_ff == 5'd4) begin
               blk_in = n16;
               ph_in = (col_ff == '0 && !fdone_ff) ? PH_FILT : PH_PIX; idx_in = 5'd0;
            end
            PH_FILT, PH_PIX: begin
               sa_in = a_n[15:0]; sb_in = b_n[15:0];
               blk_in = blk_ff - 16'd1; raw_in = raw_ff - RAW_W'(1);
               idx_in = 5'd0;
               if (ph_ff == PH_FILT) begin
                  ph_in = (blk_ff == 16'd1) ? PH_BLKH : PH_PIX;
                  fdone_in = 1'b1;
               end else begin
                  if (col_ff + DIM_W'(1) >= lw_ff) begin
                     col_in = '0; row_in = row_ff + DIM_W'(1);
                  end else col_in = col_ff + DIM_W'(1);
                  if (last_ff) ph_in = PH_TAIL;
                  else begin busy_in = 1'b0; ph_in = PH_PIXEL; end
               end
            end
            PH_TAIL: if (idx_ff == 5'd19) begin
               busy_in = 1'b0; ph_in = PH_PIXEL; started_in = 1'b0;
               col_in = '0; row_in = '0; blk_in = 16'd0; raw_in = '0;
               sa_in = 16'd1; sb_in = 16'd0; crc_in = '1;
            end
            default: ph_in = PH_PIXEL;
         endcase
      end

      // Decide on the counters as they stand after this cycle's byte.
      if (accept) begin
         pix_in = req_pixel;
         busy_in = 1'b1;
         fdone_in = 1'b0;
         last_in = (col_in + DIM_W'(1) >= (started_ff ? lw_ff : cw)) &&
                   (row_in + DIM_W'(1) >= (started_ff ? lh_ff : ch));
         if (!started_ff) begin
            lw_in = cw; lh_in = ch; started_in = 1'b1;
            ph_in = PH_SIG; idx_in = 5'd0; setup_in = 2'd3;
            hcrc_in = '1; crc_in = '1; sa_in = 16'd1; sb_in = 16'd0; blk_in = 16'd0;
         end else if (col_in == '0) begin
            ph_in = (blk_in == 16'd0) ? PH_BLKH : PH_FILT; idx_in = 5'd0;
         end else begin
            ph_in = (blk_in == 16'd0) ? PH_BLKH : PH_PIX; idx_in = 5'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= DIM_W'(16); height_ff <= DIM_W'(16);
         lw_ff <= DIM_W'(2); lh_ff <= DIM_W'(1);
         col_ff <= '0; row_ff <= '0; blk_ff <= '0; raw_ff <= '0;
         sa_ff <= 16'd1; sb_ff <= '0; crc_ff <= '1; hcrc_ff <= '1;
         started_ff <= 1'b0; ph_ff <= PH_PIXEL; idx_ff <= '0;
         busy_ff <= 1'b0; ov_ff <= 1'b0; setup_ff <= 2'd0; last_ff <= 1'b0;
         fdone_ff <= 1'b0;
      end else begin
         width_ff <= width_in; height_ff <= height_in; lw_ff <= lw_in; lh_ff <= lh_in;
         col_ff <= col_in; row_ff <= row_in; blk_ff <= blk_in; raw_ff <= raw_in;
         sa_ff <= sa_in; sb_ff <= sb_in; crc_ff <= crc_in; hcrc_ff <= hcrc_in;
         started_ff <= started_in; ph_ff <= ph_in; idx_ff <= idx_in;
         busy_ff <= busy_in; ov_ff <= ov_in; setup_ff <= setup_in; last_ff <= last_in;
         fdone_ff <= fdone_in;
      end
      zlen_ff <= zlen_in; nblk_ff <= nblk_in; pix_ff <= pix_in;
      ob_ff <= ob_in; ore_ff <= ore_in; oie_ff <= oie_in;
   end

endmodule
